FILE: design/single_qubit_state_update_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the single-qubit state update block
// Both macros sample on the rising edge of clk; SQSU_ASSERT is disabled
// while rst is high, SQSU_ASSERT_RST is checked through reset as well.
// ----------------------------------------------------------------------------
`ifndef SINGLE_QUBIT_STATE_UPDATE_DEFINES_SVH
`define SINGLE_QUBIT_STATE_UPDATE_DEFINES_SVH

// Check a property outside reset
`define SQSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property at every edge, reset included
`define SQSU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: design/sqsu_pkg.sv
// ----------------------------------------------------------------------------
// sqsu_pkg
// Shared types, widths and fixed-point helpers for the single-qubit
// state update block.
// ----------------------------------------------------------------------------
package sqsu_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int MODE_W        = 2;
  localparam int AMP_W         = 16;
  localparam int PROB_W        = 16;
  localparam int DRAW_W        = 15;
  localparam int DRAW_FRAC     = 14;
  localparam int PROD_W        = 2 * AMP_W;
  localparam int ACC_W         = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] AMP_MAX  = ACC_W'(2 ** (AMP_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] AMP_MIN  = -AMP_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] PROB_MAX = ACC_W'(2 ** PROB_W - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_RESET   = 2'd0,
    MODE_GATE    = 2'd1,
    MODE_MEASURE = 2'd2,
    MODE_HOLD    = 2'd3
  } mode_t;

  typedef logic signed [AMP_W-1:0] amp_t;

  typedef struct packed {
    amp_t a0_re;
    amp_t a0_im;
    amp_t a1_re;
    amp_t a1_im;
  } qstate_t;

  typedef struct packed {
    amp_t g00_re;
    amp_t g00_im;
    amp_t g01_re;
    amp_t g01_im;
    amp_t g10_re;
    amp_t g10_im;
    amp_t g11_re;
    amp_t g11_im;
  } gate_t;

  // Amplitude of 1.0, clipped to the largest positive value
  function automatic amp_t one_value(int unsigned frac);
    if (frac >= AMP_W - 1) begin
      return AMP_MAX[AMP_W-1:0];
    end
    return amp_t'(1 << frac);
  endfunction

  // Exact product, floor-shifted to the fraction width
  function automatic logic signed [ACC_W-1:0] mulq(amp_t a, amp_t b, int unsigned frac);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    return ACC_W'(p >>> frac);
  endfunction

  // Squared magnitude, unsaturated
  function automatic logic signed [ACC_W-1:0] mag2(amp_t re, amp_t im, int unsigned frac);
    return mulq(re, re, frac) + mulq(im, im, frac);
  endfunction

  // Clip a sum to the signed amplitude range
  function automatic amp_t sat_amp(logic signed [ACC_W-1:0] v);
    if (v > AMP_MAX) begin
      return AMP_MAX[AMP_W-1:0];
    end
    if (v < AMP_MIN) begin
      return AMP_MIN[AMP_W-1:0];
    end
    return v[AMP_W-1:0];
  endfunction

  // Clip a squared magnitude to the unsigned probability range
  function automatic logic [PROB_W-1:0] sat_prob(logic signed [ACC_W-1:0] v);
    if (v < 0) begin
      return '0;
    end
    if (v > PROB_MAX) begin
      return PROB_MAX[PROB_W-1:0];
    end
    return v[PROB_W-1:0];
  endfunction

endpackage

FILE: design/single_qubit_state_update.sv
// Throughput: one item per cycle while result_ready does not stall the output; the qubit state
//   register closes its loop directly through the gate/measure logic.
// Pipeline: input register, state update, stage register, probabilities, result register.
// Reset (rst, synchronous): state returns to |0>, all pipeline stages empty.
// ----------------------------------------------------------------------------
// single_qubit_state_update
// Holds one qubit as two Q2.14 complex amplitudes and applies reset, gate
// or measure per item, returning the new state and its probabilities.
// ----------------------------------------------------------------------------
module single_qubit_state_update #(
  parameter int FRAC_BITS = sqsu_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [sqsu_pkg::MODE_W-1:0]         mode,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g00_re,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g00_im,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g01_re,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g01_im,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g10_re,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g10_im,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g11_re,
  input  logic signed [sqsu_pkg::AMP_W-1:0]   g11_im,
  input  logic [sqsu_pkg::DRAW_W-1:0]         random_draw,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                measured_bit,
  output logic [sqsu_pkg::PROB_W-1:0]         prob_zero,
  output logic [sqsu_pkg::PROB_W-1:0]         prob_one,
  output logic signed [sqsu_pkg::AMP_W-1:0]   amp0_re_out,
  output logic signed [sqsu_pkg::AMP_W-1:0]   amp0_im_out,
  output logic signed [sqsu_pkg::AMP_W-1:0]   amp1_re_out,
  output logic signed [sqsu_pkg::AMP_W-1:0]   amp1_im_out
);
  import sqsu_pkg::*;

  localparam amp_t ONE = one_value(FRAC_BITS);

  // Input stage
  logic                  a_valid;
  mode_t                 a_mode;
  gate_t                 a_gate;
  logic [DRAW_W-1:0]     a_draw;

  // Qubit state and update stage
  qstate_t               state;
  qstate_t               state_next;
  logic                  step_bit;
  logic                  b_valid;
  logic                  b_bit;
  qstate_t               b_amp;

  // Probabilities of the staged state
  logic [PROB_W-1:0]     b_p_zero;
  logic [PROB_W-1:0]     b_p_one;

  logic                  a_ready;
  logic                  b_ready;
  logic                  c_ready;

  // Stage advance: each stage moves when the next one is free or draining
  assign c_ready    = !result_valid || result_ready;
  assign b_ready    = !b_valid || c_ready;
  assign a_ready    = !a_valid || b_ready;
  assign item_ready = a_ready;

  sqsu_step_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .mode    (a_mode),
    .gate    (a_gate),
    .draw    (a_draw),
    .cur     (state),
    .nxt     (state_next),
    .bit_out (step_bit)
  );

  sqsu_prob_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prob (
    .amp    (b_amp),
    .p_zero (b_p_zero),
    .p_one  (b_p_one)
  );

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= item_valid;
    end
    if (a_ready && item_valid) begin
      a_mode <= mode_t'(mode);
      a_gate <= '{g00_re: g00_re, g00_im: g00_im, g01_re: g01_re, g01_im: g01_im,
                  g10_re: g10_re, g10_im: g10_im, g11_re: g11_re, g11_im: g11_im};
      a_draw <= random_draw;
    end
  end

  // Update the qubit state and stage the new amplitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      state   <= '{a0_re: ONE, a0_im: '0, a1_re: '0, a1_im: '0};
    end else begin
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (b_ready && a_valid) begin
        state <= state_next;
      end
    end
    if (b_ready && a_valid) begin
      b_bit <= step_bit;
      b_amp <= state_next;
    end
  end

  // Result register with probabilities
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (c_ready) begin
      result_valid <= b_valid;
    end
    if (c_ready && b_valid) begin
      measured_bit <= b_bit;
      prob_zero    <= b_p_zero;
      prob_one     <= b_p_one;
      amp0_re_out  <= b_amp.a0_re;
      amp0_im_out  <= b_amp.a0_im;
      amp1_re_out  <= b_amp.a1_re;
      amp1_im_out  <= b_amp.a1_im;
    end
  end

endmodule

FILE: design/sqsu_step_unit.sv
// ----------------------------------------------------------------------------
// sqsu_step_unit
// Next-state logic: reset to |0>, complex 2x2 gate product with saturation,
// or measurement against a random draw with collapse; hold keeps the state.
// ----------------------------------------------------------------------------
module sqsu_step_unit #(
  parameter int FRAC_BITS = sqsu_pkg::FRAC_BITS_DEF
) (
  input  sqsu_pkg::mode_t                     mode,
  input  sqsu_pkg::gate_t                     gate,
  input  logic [sqsu_pkg::DRAW_W-1:0]         draw,
  input  sqsu_pkg::qstate_t                   cur,
  output sqsu_pkg::qstate_t                   nxt,
  output logic                                bit_out
);
  import sqsu_pkg::*;

  localparam amp_t ONE = one_value(FRAC_BITS);
  localparam int   SHL = (FRAC_BITS >= DRAW_FRAC) ? FRAC_BITS - DRAW_FRAC : 0;
  localparam int   SHR = (FRAC_BITS <  DRAW_FRAC) ? DRAW_FRAC - FRAC_BITS : 0;

  logic signed [ACC_W-1:0] sum_a0_re, sum_a0_im, sum_a1_re, sum_a1_im;
  logic signed [ACC_W-1:0] p0;
  logic        [ACC_W-1:0] draw_scaled;
  logic                    outcome;

  // Gate product, one sum per component
  always_comb begin
    sum_a0_re = mulq(gate.g00_re, cur.a0_re, FRAC_BITS) - mulq(gate.g00_im, cur.a0_im, FRAC_BITS)
              + mulq(gate.g01_re, cur.a1_re, FRAC_BITS) - mulq(gate.g01_im, cur.a1_im, FRAC_BITS);
    sum_a0_im = mulq(gate.g00_re, cur.a0_im, FRAC_BITS) + mulq(gate.g00_im, cur.a0_re, FRAC_BITS)
              + mulq(gate.g01_re, cur.a1_im, FRAC_BITS) + mulq(gate.g01_im, cur.a1_re, FRAC_BITS);
    sum_a1_re = mulq(gate.g10_re, cur.a0_re, FRAC_BITS) - mulq(gate.g10_im, cur.a0_im, FRAC_BITS)
              + mulq(gate.g11_re, cur.a1_re, FRAC_BITS) - mulq(gate.g11_im, cur.a1_im, FRAC_BITS);
    sum_a1_im = mulq(gate.g10_re, cur.a0_im, FRAC_BITS) + mulq(gate.g10_im, cur.a0_re, FRAC_BITS)
              + mulq(gate.g11_re, cur.a1_im, FRAC_BITS) + mulq(gate.g11_im, cur.a1_re, FRAC_BITS);
  end

  // Measure: rescale the draw and compare with the zero probability
  always_comb begin
    p0          = mag2(cur.a0_re, cur.a0_im, FRAC_BITS);
    draw_scaled = (ACC_W'(draw) << SHL) >> SHR;
    outcome     = !($signed(draw_scaled) < p0);
  end

  // Select the next state by mode
  always_comb begin
    nxt     = cur;
    bit_out = 1'b0;
    unique case (mode)
      MODE_RESET: begin
        nxt = '{a0_re: ONE, a0_im: '0, a1_re: '0, a1_im: '0};
      end
      MODE_GATE: begin
        nxt = '{a0_re: sat_amp(sum_a0_re), a0_im: sat_amp(sum_a0_im),
                a1_re: sat_amp(sum_a1_re), a1_im: sat_amp(sum_a1_im)};
      end
      MODE_MEASURE: begin
        bit_out = outcome;
        nxt     = '{a0_re: outcome ? amp_t'(0) : ONE, a0_im: '0,
                    a1_re: outcome ? ONE : amp_t'(0), a1_im: '0};
      end
      MODE_HOLD: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: design/sqsu_prob_unit.sv
// ----------------------------------------------------------------------------
// sqsu_prob_unit
// Squared magnitudes of both amplitudes, clipped to the unsigned
// probability range.
// ----------------------------------------------------------------------------
module sqsu_prob_unit #(
  parameter int FRAC_BITS = sqsu_pkg::FRAC_BITS_DEF
) (
  input  sqsu_pkg::qstate_t             amp,
  output logic [sqsu_pkg::PROB_W-1:0]   p_zero,
  output logic [sqsu_pkg::PROB_W-1:0]   p_one
);
  import sqsu_pkg::*;

  // Square and clip each amplitude
  always_comb begin
    p_zero = sat_prob(mag2(amp.a0_re, amp.a0_im, FRAC_BITS));
    p_one  = sat_prob(mag2(amp.a1_re, amp.a1_im, FRAC_BITS));
  end

endmodule

FILE: design/sqsu_checker.sv
// ----------------------------------------------------------------------------
// sqsu_checker
// Port-level checks for the single-qubit state update block, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "single_qubit_state_update_defines.svh"

module sqsu_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic                                measured_bit,
  input logic [sqsu_pkg::PROB_W-1:0]         prob_zero,
  input logic [sqsu_pkg::PROB_W-1:0]         prob_one,
  input logic signed [sqsu_pkg::AMP_W-1:0]   amp0_re_out,
  input logic signed [sqsu_pkg::AMP_W-1:0]   amp0_im_out,
  input logic signed [sqsu_pkg::AMP_W-1:0]   amp1_re_out,
  input logic signed [sqsu_pkg::AMP_W-1:0]   amp1_im_out
);

  // Reset empties the result register
  `SQSU_ASSERT_RST(a_reset_empties, rst |=> !result_valid, "result valid after reset")

  // Outcome one leaves the qubit in |1> with a real amplitude
  `SQSU_ASSERT(a_one_collapse, result_valid && measured_bit |-> amp0_re_out == 0 && amp0_im_out == 0 && amp1_im_out == 0, "outcome one without collapse to |1>")

  // A zero |1> amplitude has zero probability of outcome one
  `SQSU_ASSERT(a_zero_prob, result_valid && amp1_re_out == 0 && amp1_im_out == 0 |-> prob_one == 0, "nonzero probability for zero amplitude")

  // Hold a stalled result
  `SQSU_ASSERT(a_stall_hold, result_valid && !result_ready |=> result_valid && $stable(prob_zero) && $stable(amp0_re_out), "stalled result changed")

endmodule

bind single_qubit_state_update sqsu_checker u_sqsu_checker (.*);
